@@ sv/pdbd_pkg.sv @@
// ----------------------------------------------------------------------------
// pdbd_pkg
// Shared types and constants of the pulse-width bit decoder.
// ----------------------------------------------------------------------------
package pdbd_pkg;

    localparam int PeriodW     = 16;
    localparam int HighW       = 16;
    localparam int WordW       = 16;
    localparam int JitterW     = 10;
    localparam int PdCodeW     = 8;
    localparam int WordBitsDef = 16;
    localparam int QueueDepth  = 2;

    localparam int unsigned CfgIdxW = 1;

    localparam logic [CfgIdxW-1:0] CFG_JITTER = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_PDCODE = 1'd1;

    localparam logic [JitterW-1:0] JitterRst = 10'd4;
    localparam logic [PdCodeW-1:0] PdCodeRst = 8'hfe;

    // Pulse class codes
    typedef logic [1:0] t_cls;
    localparam t_cls CLS_MARK = 2'd0;
    localparam t_cls CLS_ZERO = 2'd1;
    localparam t_cls CLS_ONE  = 2'd2;

    typedef struct packed {
        t_cls cls;
    } t_qent;

    typedef struct packed {
        logic [JitterW-1:0] jitter;
        logic [PdCodeW-1:0] pdcode;
    } t_cfg;

endpackage

@@ sv/pwm_duty_bit_decoder_top.sv @@
// ----------------------------------------------------------------------------
// pwm_duty_bit_decoder_top
// Pulse-width bit decoder: turns captured pulse widths into 16-bit words.
// ----------------------------------------------------------------------------
// Takes one pulse per clock unless the queue is full; a pulse is classified in
// the cycle it is accepted and queued. The shifter dequeues one pulse per clock
// unless a held beat waits; a mark's word passes the queue and output register.
// Throughput is one beat per cycle while the master accepts; its back-pressure
// fills the two-entry queue before the slave side stalls. The user must write
// configuration only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module pwm_duty_bit_decoder_top #(
    parameter int WORD_BITS = pdbd_pkg::WordBitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic                          i_cfg_we,
    input  logic [pdbd_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [pdbd_pkg::JitterW-1:0]  i_cfg_wdata,
    // slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] period_count, [31:16] high_count
    // master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] word
    output logic        m_axis_tuser    // [0] is_powerdown
);
    import pdbd_pkg::*;

    t_cfg  r_cfg;
    logic  keep;
    t_qent f_ent;
    t_qent q_ent;
    logic  q_full;
    logic  q_empty;
    logic  pop;
    logic  push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.jitter <= JitterRst;
            r_cfg.pdcode <= PdCodeRst;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_JITTER: r_cfg.jitter <= i_cfg_wdata;
                CFG_PDCODE: r_cfg.pdcode <= i_cfg_wdata[PdCodeW-1:0];
                default:    r_cfg        <= r_cfg;
            endcase
        end
    end

    assign s_axis_tready = !q_full;
    assign push          = s_axis_tvalid && s_axis_tready && keep;

    pdbd_front u_front (
        .i_period (s_axis_tdata[PeriodW-1:0]),
        .i_high   (s_axis_tdata[PeriodW+HighW-1:PeriodW]),
        .i_jitter (r_cfg.jitter),
        .o_keep   (keep),
        .o_ent    (f_ent)
    );

    pdbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (f_ent),
        .o_full  (q_full),
        .o_empty (q_empty),
        .i_pop   (pop),
        .o_ent   (q_ent)
    );

    pdbd_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_avail  (!q_empty),
        .i_ent    (q_ent),
        .o_pop    (pop),
        .i_pdcode (r_cfg.pdcode),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_word   (m_axis_tdata),
        .o_pd     (m_axis_tuser)
    );

endmodule

@@ sv/pdbd_front.sv @@
// ----------------------------------------------------------------------------
// pdbd_front
// Classifies one pulse per cycle against half, quarter and three-quarter period.
// ----------------------------------------------------------------------------
module pdbd_front (
    input  logic [pdbd_pkg::PeriodW-1:0] i_period,
    input  logic [pdbd_pkg::HighW-1:0]   i_high,
    input  logic [pdbd_pkg::JitterW-1:0] i_jitter,
    output logic                         o_keep,
    output pdbd_pkg::t_qent              o_ent
);
    import pdbd_pkg::*;

    localparam int DiffW = PeriodW + 2;

    logic signed [DiffW-1:0] half_s;
    logic signed [DiffW-1:0] quarter_s;
    logic signed [DiffW-1:0] tq_s;
    logic signed [DiffW-1:0] high_s;
    logic signed [DiffW-1:0] jit_s;
    logic signed [DiffW-1:0] d_half;
    logic signed [DiffW-1:0] d_quarter;
    logic signed [DiffW-1:0] d_tq;
    logic                    ok_half;
    logic                    ok_quarter;
    logic                    ok_tq;

    always_comb begin
        half_s    = signed'(DiffW'({1'b0, i_period[PeriodW-1:1]}));
        quarter_s = signed'(DiffW'({2'b0, i_period[PeriodW-1:2]}));
        tq_s      = half_s + quarter_s;
        high_s    = signed'(DiffW'(i_high));
        jit_s     = signed'(DiffW'(i_jitter));
        d_half    = half_s - high_s;
        d_quarter = quarter_s - high_s;
        d_tq      = tq_s - high_s;
        // strict window both ways; zero jitter never passes
        ok_half    = (d_half < jit_s) && (d_half > -jit_s);
        ok_quarter = (d_quarter < jit_s) && (d_quarter > -jit_s);
        ok_tq      = (d_tq < jit_s) && (d_tq > -jit_s);
    end

    always_comb begin
        o_keep    = 1'b1;
        o_ent.cls = CLS_MARK;
        priority if (ok_half) begin
            o_ent.cls = CLS_MARK;
        end else if (ok_quarter) begin
            o_ent.cls = CLS_ZERO;
        end else if (ok_tq) begin
            o_ent.cls = CLS_ONE;
        end else begin
            o_keep = 1'b0;
        end
    end

endmodule

@@ sv/pdbd_queue.sv @@
// ----------------------------------------------------------------------------
// pdbd_queue
// Short queue of classified pulses between front and back.
// ----------------------------------------------------------------------------
module pdbd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pdbd_pkg::t_qent i_ent,
    output logic            o_full,
    output logic            o_empty,
    input  logic            i_pop,
    output pdbd_pkg::t_qent o_ent
);
    import pdbd_pkg::*;

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW = $clog2(QueueDepth + 1);

    t_qent            r_mem [QueueDepth];
    logic [PtrW-1:0]  r_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr;
    logic [CntW-1:0]  r_cnt;
    logic [PtrW-1:0]  n_wr_ptr;
    logic [PtrW-1:0]  n_rd_ptr;
    logic [CntW-1:0]  n_cnt;

    assign o_full  = (r_cnt == CntW'(QueueDepth));
    assign o_empty = (r_cnt == '0);
    assign o_ent   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_ent;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue pop while empty");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(QueueDepth))
        else $error("queue fill count out of range");

endmodule

@@ sv/pdbd_back.sv @@
// ----------------------------------------------------------------------------
// pdbd_back
// Shifts in data bits, emits on a mark after exactly WORD_BITS, holds the beat.
// ----------------------------------------------------------------------------
module pdbd_back #(
    parameter int WORD_BITS = pdbd_pkg::WordBitsDef
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_avail,
    input  pdbd_pkg::t_qent              i_ent,
    output logic                         o_pop,
    input  logic [pdbd_pkg::PdCodeW-1:0] i_pdcode,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [pdbd_pkg::WordW-1:0]   o_word,
    output logic                         o_pd
);
    import pdbd_pkg::*;

    localparam int CntW = $clog2(WORD_BITS + 2);
    localparam logic [CntW-1:0] CntFull = CntW'(WORD_BITS);
    localparam logic [CntW-1:0] CntSat  = CntW'(WORD_BITS + 1);

    logic [WordW-1:0] r_shift;
    logic [CntW-1:0]  r_count;
    logic             r_valid;
    logic [WordW-1:0] r_word;
    logic             r_pd;
    logic [WordW-1:0] n_shift;
    logic [CntW-1:0]  n_count;
    logic             emit;

    assign o_pop   = i_avail && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_word  = r_word;
    assign o_pd    = r_pd;

    always_comb begin
        n_shift = r_shift;
        n_count = r_count;
        emit    = 1'b0;
        unique case (i_ent.cls)
            CLS_MARK: begin
                emit    = (r_count == CntFull);
                n_shift = '0;
                n_count = '0;
            end
            CLS_ZERO, CLS_ONE: begin
                n_shift = {r_shift[WordW-2:0], (i_ent.cls == CLS_ONE)};
                if (r_count < CntSat) begin
                    n_count = r_count + 1'b1;
                end
            end
            default: begin
                n_shift = r_shift;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_shift <= n_shift;
                r_count <= n_count;
            end
            if (o_pop && emit) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_word <= r_shift;
            r_pd   <= (r_shift[WordW-1:WordW-8] == i_pdcode);
        end
    end

    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntSat)
        else $error("bit count beyond saturation");

    a_rise_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_valid) |-> $past(o_pop))
        else $error("output beat without a dequeued mark");

    a_mark_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_ent.cls == CLS_MARK) |=> (r_count == '0 && r_shift == '0))
        else $error("mark did not clear the word");

endmodule
